/* hw/rtl/smpwm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpwm_pkg
// Shared types and constants of the staggered multichannel servo PWM block.
// ----------------------------------------------------------------------------
package smpwm_pkg;

  localparam int CHANNELS     = 8;
  localparam int COUNT_BITS   = 24;
  localparam int PERIOD_BITS  = 24;
  localparam int STAGGER_BITS = 16;
  localparam int RANK_BITS    = $clog2(CHANNELS);
  localparam int PROD_BITS    = STAGGER_BITS + RANK_BITS + 1;
  localparam int SUM_BITS     = ((PROD_BITS > COUNT_BITS) ? PROD_BITS : COUNT_BITS) + 1;
  localparam int CMP_BITS     = (PERIOD_BITS > COUNT_BITS) ? PERIOD_BITS : COUNT_BITS;
  localparam int ADDR_BITS    = 3;
  localparam int DATA_BITS    = 32;

  localparam logic [PERIOD_BITS-1:0]  PERIOD_RESET  = PERIOD_BITS'(800000);
  localparam logic [STAGGER_BITS-1:0] STAGGER_RESET = STAGGER_BITS'(200);
  localparam logic [COUNT_BITS-1:0]   WIDTH_RESET   = COUNT_BITS'(200000);

  // Input item function codes.
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_WIDTH  = 2'd1;
  localparam logic [1:0] FUNC_ENABLE = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_PERIOD  = 1'b0;
  localparam logic REG_STAGGER = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  channel;
    logic [23:0] pulse_width;
    logic [7:0]  enable_mask;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pwm_out;
    logic       frame_start;
  } out_item_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0]  period;
    logic [STAGGER_BITS-1:0] stagger;
  } cfg_t;

endpackage

/* hw/rtl/staggered_multichannel_servo_pwm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staggered_multichannel_servo_pwm
// Eight-channel servo PWM generator with staggered turn-on by width rank.
// ----------------------------------------------------------------------------
// Each input transaction yields one result transaction. A width or enable
// write sets the engine's done flag, and its result is then registered in
// the output register. A timer tick evaluates the channels one at a time:
// each channel's turn-on time is formed by one shared multiplier in S_MUL
// and then checked by one shared adder and two comparators in S_CMP, and after
// the last channel the frame count is updated and the levels move out. A
// tick that opens a new frame adds the ranking pass first, in which a
// separate comparator on the shared width read port orders the latched
// widths one pair per cycle. One transaction is in work at a time; the next
// is taken once the engine is free and the output register is empty
// or being emptied.
module staggered_multichannel_servo_pwm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  smpwm_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output smpwm_pkg::out_item_t             out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [smpwm_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [smpwm_pkg::DATA_BITS-1:0]  pwdata,
  output logic [smpwm_pkg::DATA_BITS-1:0]  prdata,
  output logic                             pready
);

  smpwm_pkg::cfg_t      cfg;
  smpwm_pkg::out_item_t eng_result;
  logic                 eng_busy;
  logic                 eng_done;
  logic                 accept;

  assign in_stall = eng_busy || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  smpwm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smpwm_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .go     (accept),
    .item   (in_data),
    .cfg    (cfg),
    .busy   (eng_busy),
    .done   (eng_done),
    .result (eng_result)
  );

  // Output register; a finished result never meets a full register because
  // a transaction is only accepted when this register is free or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_done) begin
      out_valid <= 1'b1;
      out_data  <= eng_result;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hw/rtl/smpwm_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpwm_regs
// APB register file holding the frame period and the turn-on stagger.
// ----------------------------------------------------------------------------
module smpwm_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [smpwm_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [smpwm_pkg::DATA_BITS-1:0]      pwdata,
  output logic [smpwm_pkg::DATA_BITS-1:0]      prdata,
  output logic                                 pready,
  output smpwm_pkg::cfg_t                      cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period  <= smpwm_pkg::PERIOD_RESET;
      cfg.stagger <= smpwm_pkg::STAGGER_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        smpwm_pkg::REG_PERIOD:  cfg.period  <= pwdata[smpwm_pkg::PERIOD_BITS-1:0];
        smpwm_pkg::REG_STAGGER: cfg.stagger <= pwdata[smpwm_pkg::STAGGER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      smpwm_pkg::REG_PERIOD:  prdata = smpwm_pkg::DATA_BITS'(cfg.period);
      smpwm_pkg::REG_STAGGER: prdata = smpwm_pkg::DATA_BITS'(cfg.stagger);
      default:                prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/smpwm_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpwm_engine
// Channel state and the sequencer that ranks channels and evaluates levels
// one channel at a time through a shared multiplier, adder and comparator.
// ----------------------------------------------------------------------------
module smpwm_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  smpwm_pkg::in_item_t   item,
  input  smpwm_pkg::cfg_t       cfg,
  output logic                  busy,
  output logic                  done,
  output smpwm_pkg::out_item_t  result
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RKEY = 5'b00010,
    S_RCMP = 5'b00100,
    S_MUL  = 5'b01000,
    S_CMP  = 5'b10000
  } state_t;

  localparam logic [smpwm_pkg::RANK_BITS-1:0] LAST = smpwm_pkg::RANK_BITS'(smpwm_pkg::CHANNELS - 1);

  state_t state;
  logic   fin;

  logic [smpwm_pkg::COUNT_BITS-1:0]  frame_count;
  logic [smpwm_pkg::COUNT_BITS-1:0]  shadow_width [smpwm_pkg::CHANNELS];
  logic [smpwm_pkg::COUNT_BITS-1:0]  active_width [smpwm_pkg::CHANNELS];
  logic [smpwm_pkg::RANK_BITS-1:0]   channel_rank [smpwm_pkg::CHANNELS];
  logic [smpwm_pkg::CHANNELS-1:0]    shadow_enable;
  logic [smpwm_pkg::CHANNELS-1:0]    active_enable;
  logic [smpwm_pkg::CHANNELS-1:0]    pwm_level;
  logic [smpwm_pkg::CHANNELS-1:0]    level_acc;
  logic [smpwm_pkg::PERIOD_BITS-1:0] period_eff;
  logic                              start_flag;

  logic [smpwm_pkg::RANK_BITS-1:0]   idx_a;
  logic [smpwm_pkg::RANK_BITS-1:0]   idx_b;
  logic [smpwm_pkg::RANK_BITS-1:0]   idx_i;
  logic [smpwm_pkg::RANK_BITS-1:0]   rank_acc;
  logic [smpwm_pkg::COUNT_BITS-1:0]  key;
  logic [smpwm_pkg::PROD_BITS-1:0]   prod;

  logic [smpwm_pkg::RANK_BITS-1:0]   rd_idx;
  logic [smpwm_pkg::COUNT_BITS-1:0]  rd_width;
  logic [smpwm_pkg::RANK_BITS:0]     rank_p1;
  logic [smpwm_pkg::PERIOD_BITS-1:0] period_now;
  logic                              new_frame;
  logic                              less;
  logic [smpwm_pkg::RANK_BITS-1:0]   rank_acc_next;
  logic [smpwm_pkg::SUM_BITS-1:0]    off_time;
  logic                              hit;
  logic [smpwm_pkg::CHANNELS-1:0]    level_next;
  logic [smpwm_pkg::COUNT_BITS-1:0]  count_inc;

  // The engine stays busy while a transaction is in work and while done is high.
  assign busy = (state != S_IDLE) || fin || done;

  // Single read port into the active widths, shared by ranking and levels.
  always_comb begin
    unique case (state)
      S_RKEY:  rd_idx = idx_a;
      S_RCMP:  rd_idx = idx_b;
      default: rd_idx = idx_i;
    endcase
  end
  assign rd_width = active_width[rd_idx];

  assign period_now = (cfg.period == '0) ? smpwm_pkg::PERIOD_BITS'(1) : cfg.period;
  assign new_frame  = (frame_count == '0) ||
                      (smpwm_pkg::CMP_BITS'(frame_count) >= smpwm_pkg::CMP_BITS'(period_now));

  // Lower width ranks first; equal widths are ordered by channel index.
  assign less          = (rd_width < key) || ((rd_width == key) && (idx_b < idx_a));
  assign rank_acc_next = rank_acc + smpwm_pkg::RANK_BITS'(less);

  assign rank_p1  = {1'b0, channel_rank[idx_i]} + 1'b1;
  assign off_time = smpwm_pkg::SUM_BITS'(prod) + smpwm_pkg::SUM_BITS'(rd_width);
  assign hit      = active_enable[idx_i] &&
                    (smpwm_pkg::SUM_BITS'(frame_count) >= smpwm_pkg::SUM_BITS'(prod)) &&
                    (smpwm_pkg::SUM_BITS'(frame_count) < off_time);

  always_comb begin
    level_next        = level_acc;
    level_next[idx_i] = hit;
  end

  assign count_inc = frame_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      fin           <= 1'b0;
      frame_count   <= '0;
      shadow_enable <= '1;
      active_enable <= '1;
      pwm_level     <= '0;
      for (int k = 0; k < smpwm_pkg::CHANNELS; k++) begin
        shadow_width[k] <= smpwm_pkg::WIDTH_RESET;
        active_width[k] <= smpwm_pkg::WIDTH_RESET;
        channel_rank[k] <= smpwm_pkg::RANK_BITS'(k);
      end
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      // The count update comes in the cycle after the last channel is evaluated, on the registered fin flag.
      if (fin) begin
        pwm_level          <= level_acc;
        result.pwm_out     <= 8'(level_acc);
        result.frame_start <= start_flag;
        done               <= 1'b1;
        if (smpwm_pkg::CMP_BITS'(count_inc) >= smpwm_pkg::CMP_BITS'(period_eff)) begin
          frame_count <= '0;
        end else begin
          frame_count <= count_inc;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (go) begin
            case (item.func)
              smpwm_pkg::FUNC_TICK: begin
                period_eff <= period_now;
                idx_i      <= '0;
                start_flag <= new_frame;
                if (new_frame) begin
                  frame_count   <= '0;
                  active_enable <= shadow_enable;
                  for (int k = 0; k < smpwm_pkg::CHANNELS; k++) begin
                    active_width[k] <= shadow_width[k];
                  end
                  idx_a <= '0;
                  state <= S_RKEY;
                end else begin
                  state <= S_MUL;
                end
              end
              smpwm_pkg::FUNC_WIDTH: begin
                if (32'(item.channel) < smpwm_pkg::CHANNELS) begin
                  shadow_width[smpwm_pkg::RANK_BITS'(item.channel)] <=
                    smpwm_pkg::COUNT_BITS'(item.pulse_width);
                end
                done <= 1'b1;
              end
              smpwm_pkg::FUNC_ENABLE: begin
                shadow_enable <= smpwm_pkg::CHANNELS'(item.enable_mask);
                done          <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
            if (item.func != smpwm_pkg::FUNC_TICK) begin
              result.pwm_out     <= 8'(pwm_level);
              result.frame_start <= 1'b0;
            end
          end
        end
        S_RKEY: begin
          key      <= rd_width;
          rank_acc <= '0;
          idx_b    <= '0;
          state    <= S_RCMP;
        end
        S_RCMP: begin
          rank_acc <= rank_acc_next;
          idx_b    <= idx_b + 1'b1;
          if (idx_b == LAST) begin
            channel_rank[idx_a] <= rank_acc_next;
            if (idx_a == LAST) begin
              state <= S_MUL;
            end else begin
              idx_a <= idx_a + 1'b1;
              state <= S_RKEY;
            end
          end
        end
        S_MUL: begin
          prod  <= smpwm_pkg::PROD_BITS'(cfg.stagger) * smpwm_pkg::PROD_BITS'(rank_p1);
          state <= S_CMP;
        end
        S_CMP: begin
          level_acc <= level_next;
          if (idx_i == LAST) begin
            fin   <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx_i <= idx_i + 1'b1;
            state <= S_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
